// File: rtl/core/dda_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// cond at one edge implies expr at the next edge
`define DDA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dda assertion failed: next-cycle check");

// cond implies expr at the same edge
`define DDA_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dda assertion failed: same-cycle check");

// expr holds at every edge out of reset
`define DDA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("dda assertion failed: invariant");

`endif

// File: rtl/core/dda_pkg.sv
// Shared constants and controller/datapath interface types for the DDA rasterizer.
package dda_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;

   // quotient width: |delta| << FRAC_BITS
   localparam int QUO_W     = COORD_BITS + FRAC_BITS;
   // accumulator: sign + integer + fraction
   localparam int ACC_W     = QUO_W + 1;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef struct packed {
      logic load_start;
      logic advance;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
   } sts_type;

endpackage

// File: rtl/core/dda_ctrl.sv
// Sequencer for the DDA rasterizer: handshakes, divider pacing, output valid.
`include "dda_line_rasterizer_macros.svh"

module dda_ctrl
   import dda_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_type,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [0:0] {S_READY, S_DIV} state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 req_accept;

   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      req_stall      = (state_ff != S_READY) || !out_free;
      req_accept     = req_valid && !req_stall;
      cmd.load_start = req_accept && (req_type == REQ_START);
      cmd.advance    = req_accept && (req_type == REQ_ADVANCE);
      cmd.div_step   = (state_ff == S_DIV);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end

      case (state_ff)
         S_READY: begin
            if (cmd.load_start && !sts.steps_zero) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_READY;
               cnt_in   = '0;
            end
         end
         default: begin
            state_in = S_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DDA_ASSERT_NEXT(a_start_divides, clock, reset, cmd.load_start && !sts.steps_zero, state_ff == S_DIV)
   `DDA_ASSERT_NEXT(a_accept_fills_out, clock, reset, req_accept, rsp_valid_ff)
   `DDA_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= DIV_LAST)

endmodule

// File: rtl/core/dda_dpath.sv
// Datapath for the DDA rasterizer: setup, two restoring dividers, accumulators, output.
`include "dda_line_rasterizer_macros.svh"

module dda_dpath
   import dda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_last_pixel
);

   logic [ACC_W-1:0]      acc_x_ff, acc_y_ff;
   logic [QUO_W-1:0]      quo_x_ff, quo_y_ff, quo_x_in, quo_y_in;
   logic [COORD_BITS-1:0] rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic                  neg_x_ff, neg_y_ff;
   logic [COORD_BITS-1:0] steps_left_ff;
   logic                  line_active_ff;
   logic [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic                  pix_valid_ff, last_ff;

   logic [COORD_BITS-1:0] ax, ay, steps_start;
   logic                  neg_x, neg_y;
   logic [ACC_W-1:0]      acc_x_adv, acc_y_adv;
   logic                  final_step;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic logic [COORD_BITS+QUO_W-1:0] div_iter(
      input logic [COORD_BITS-1:0] rem,
      input logic [QUO_W-1:0]      quo,
      input logic [COORD_BITS-1:0] divisor
   );
      logic [COORD_BITS:0] shifted;
      logic [COORD_BITS:0] diff;
      logic                fit;
      shifted = {rem, quo[QUO_W-1]};
      diff    = shifted - {1'b0, divisor};
      fit     = (shifted >= {1'b0, divisor});
      return {(fit ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0]),
              quo[QUO_W-2:0], fit};
   endfunction

   function automatic logic [COORD_BITS-1:0] pixel_of(input logic [ACC_W-1:0] acc);
      return acc[ACC_W-1] ? '0 : acc[FRAC_BITS +: COORD_BITS];
   endfunction

   always_comb begin
      neg_x       = (req_x_end < req_x_start);
      neg_y       = (req_y_end < req_y_start);
      ax          = neg_x ? (req_x_start - req_x_end) : (req_x_end - req_x_start);
      ay          = neg_y ? (req_y_start - req_y_end) : (req_y_end - req_y_start);
      steps_start = (ax >= ay) ? ax : ay;
      sts.steps_zero = (steps_start == '0);

      {rem_x_in, quo_x_in} = div_iter(rem_x_ff, quo_x_ff, steps_left_ff);
      {rem_y_in, quo_y_in} = div_iter(rem_y_ff, quo_y_ff, steps_left_ff);

      acc_x_adv = neg_x_ff ? (acc_x_ff - {1'b0, quo_x_ff}) : (acc_x_ff + {1'b0, quo_x_ff});
      acc_y_adv = neg_y_ff ? (acc_y_ff - {1'b0, quo_y_ff}) : (acc_y_ff + {1'b0, quo_y_ff});
      final_step = (steps_left_ff == COORD_BITS'(1));
   end

   // line control state
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
      end else if (cmd.load_start) begin
         steps_left_ff  <= steps_start;
         line_active_ff <= !sts.steps_zero;
      end else if (cmd.advance && line_active_ff) begin
         steps_left_ff <= steps_left_ff - COORD_BITS'(1);
         if (final_step) begin
            line_active_ff <= 1'b0;
         end
      end
   end

   // arithmetic and output payload
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         acc_x_ff     <= {1'b0, req_x_start, {FRAC_BITS{1'b0}}};
         acc_y_ff     <= {1'b0, req_y_start, {FRAC_BITS{1'b0}}};
         quo_x_ff     <= {ax, {FRAC_BITS{1'b0}}};
         quo_y_ff     <= {ay, {FRAC_BITS{1'b0}}};
         rem_x_ff     <= '0;
         rem_y_ff     <= '0;
         neg_x_ff     <= neg_x;
         neg_y_ff     <= neg_y;
         pix_x_ff     <= req_x_start;
         pix_y_ff     <= req_y_start;
         pix_valid_ff <= 1'b1;
         last_ff      <= sts.steps_zero;
      end else if (cmd.div_step) begin
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
      end else if (cmd.advance) begin
         if (line_active_ff) begin
            acc_x_ff     <= acc_x_adv;
            acc_y_ff     <= acc_y_adv;
            pix_x_ff     <= pixel_of(acc_x_adv);
            pix_y_ff     <= pixel_of(acc_y_adv);
            pix_valid_ff <= 1'b1;
            last_ff      <= final_step;
         end else begin
            pix_x_ff     <= '0;
            pix_y_ff     <= '0;
            pix_valid_ff <= 1'b0;
            last_ff      <= 1'b0;
         end
      end
   end

   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_pixel_valid = pix_valid_ff;
   assign rsp_last_pixel  = last_ff;

   `DDA_ASSERT_ALWAYS(a_active_matches_steps, clock, reset, line_active_ff == (steps_left_ff != '0))

endmodule

// File: rtl/core/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | type, x/y start, x/y end
//   rsp     | out       | rsp_valid/rsp_stall  | pixel x/y, pixel valid, last pixel
//
// Advances stream one per cycle while rsp is not stalled and no divide is running.
// A start puts the start pixel in the output register at once, then stalls req
// while two bit-serial restoring dividers form the increments; a zero-length line skips
// the divide.
// Reset is synchronous and leaves the block idle with no line active.
// A held rsp_stall with rsp_valid high freezes the output register and stalls req behind it.

module dda_line_rasterizer
   import dda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_last_pixel
);

   cmd_type cmd;
   sts_type sts;

   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dda_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
